// ----- hw/rtl/iwq_pkg.sv -----
// ----------------------------------------------------------------------------
// iwq_pkg
// Shared types, register indexes and helpers of the index word qualifier.
// ----------------------------------------------------------------------------
package iwq_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned VOWEL_W = 26;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned DATA_W  = 26;

	localparam logic [INDEX_W-1:0] REG_MIN_LENGTH        = 8'd0;
	localparam logic [INDEX_W-1:0] REG_MAX_LENGTH        = 8'd1;
	localparam logic [INDEX_W-1:0] REG_MAX_SAME_REPEAT   = 8'd2;
	localparam logic [INDEX_W-1:0] REG_MAX_DIGIT_RUN     = 8'd3;
	localparam logic [INDEX_W-1:0] REG_MAX_VOWEL_RUN     = 8'd4;
	localparam logic [INDEX_W-1:0] REG_MAX_CONSONANT_RUN = 8'd5;
	localparam logic [INDEX_W-1:0] REG_VOWEL_LETTERS     = 8'd6;
	localparam logic [INDEX_W-1:0] REG_REJECT_MODES      = 8'd7;

	localparam logic [LIMIT_W-1:0] RST_MIN_LENGTH        = 8'd1;
	localparam logic [LIMIT_W-1:0] RST_MAX_LENGTH        = 8'd40;
	localparam logic [LIMIT_W-1:0] RST_MAX_SAME_REPEAT   = 8'd100;
	localparam logic [LIMIT_W-1:0] RST_MAX_DIGIT_RUN     = 8'd100;
	localparam logic [LIMIT_W-1:0] RST_MAX_VOWEL_RUN     = 8'd10;
	localparam logic [LIMIT_W-1:0] RST_MAX_CONSONANT_RUN = 8'd10;
	localparam logic [VOWEL_W-1:0] RST_VOWEL_LETTERS     = 26'h0104111;
	localparam logic [MODE_W-1:0]  RST_REJECT_MODES      = 3'd0;

	localparam int unsigned MODE_ALL_VOWEL     = 0;
	localparam int unsigned MODE_ALL_CONSONANT = 1;
	localparam int unsigned MODE_ALL_DIGIT     = 2;

	typedef struct packed {
		logic [LIMIT_W-1:0] min_length;
		logic [LIMIT_W-1:0] max_length;
		logic [LIMIT_W-1:0] max_same_repeat;
		logic [LIMIT_W-1:0] max_digit_run;
		logic [LIMIT_W-1:0] max_vowel_run;
		logic [LIMIT_W-1:0] max_consonant_run;
		logic [VOWEL_W-1:0] vowel_letters;
		logic [MODE_W-1:0]  reject_modes;
	} cfg_t;

	typedef struct packed {
		logic is_digit;
		logic is_vowel;
		logic is_consonant;
	} char_class_t;

	typedef struct packed {
		logic step;
		logic word_end;
		logic is_stopword;
	} step_t;

	// Counters stop at 256, the only reachable value with the top bit set.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = v[CNT_W-1] ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

// ----- hw/rtl/index_word_qualifier.sv -----
// ----------------------------------------------------------------------------
// index_word_qualifier
// Qualifies words for indexing from a byte stream with terminator items.
// ----------------------------------------------------------------------------
// The block takes one item per cycle (a byte of the word, or a terminator
// that carries the stopword verdict) unless a terminator is held back as
// below. Each transfer lands in an input register and the word counters
// update from it as it leaves that register. A terminator loads the accept
// flag into the result register as it leaves, and the result is offered
// from that register. While a result waits to be taken,
// byte items still flow; a second terminator waits in the input register
// until the result register frees, which is the only case of back pressure.
module index_word_qualifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [iwq_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [iwq_pkg::DATA_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [iwq_pkg::CHAR_W-1:0]   char_code,
	input  logic                         word_end,
	input  logic                         is_stopword,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accept
);

	iwq_pkg::cfg_t        cfg;
	iwq_pkg::char_class_t char_class;
	iwq_pkg::step_t       step;

	logic                       valid_s1;
	logic [iwq_pkg::CHAR_W-1:0] char_code_s1;
	logic                       word_end_s1;
	logic                       is_stopword_s1;
	logic                       advance;
	logic                       verdict;
	logic                       out_valid_q;
	logic                       accept_q;

	assign advance  = valid_s1 && (!word_end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_code_s1   <= char_code;
			word_end_s1    <= word_end;
			is_stopword_s1 <= is_stopword;
		end
	end

	iwq_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	iwq_char_class u_char_class (
		.char_code     (char_code_s1),
		.vowel_letters (cfg.vowel_letters),
		.char_class    (char_class)
	);

	always_comb begin
		step.step        = advance;
		step.word_end    = word_end_s1;
		step.is_stopword = is_stopword_s1;
	end

	iwq_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.char_code  (char_code_s1),
		.char_class (char_class),
		.cfg        (cfg),
		.accept     (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_end_s1) begin
			accept_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign accept    = accept_q;

`ifndef ASSERT_OFF
	a_result_from_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && word_end_s1 && advance))
		else $error("result appeared without a terminator transfer");

	a_terminator_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && word_end_s1 && advance) |=> out_valid_q)
		else $error("terminator left the input stage without a result");

	a_stalled_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(word_end_s1)))
		else $error("stalled input item was lost");

	a_stall_only_on_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !word_end_s1) |-> advance)
		else $error("byte item stalled in the input stage");
`endif

endmodule

// ----- hw/rtl/iwq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// iwq_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module iwq_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [iwq_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [iwq_pkg::DATA_W-1:0]   cfg_wdata,
	output iwq_pkg::cfg_t                cfg
);

	iwq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length        <= iwq_pkg::RST_MIN_LENGTH;
			cfg_q.max_length        <= iwq_pkg::RST_MAX_LENGTH;
			cfg_q.max_same_repeat   <= iwq_pkg::RST_MAX_SAME_REPEAT;
			cfg_q.max_digit_run     <= iwq_pkg::RST_MAX_DIGIT_RUN;
			cfg_q.max_vowel_run     <= iwq_pkg::RST_MAX_VOWEL_RUN;
			cfg_q.max_consonant_run <= iwq_pkg::RST_MAX_CONSONANT_RUN;
			cfg_q.vowel_letters     <= iwq_pkg::RST_VOWEL_LETTERS;
			cfg_q.reject_modes      <= iwq_pkg::RST_REJECT_MODES;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				iwq_pkg::REG_MIN_LENGTH: begin
					cfg_q.min_length <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_MAX_LENGTH: begin
					cfg_q.max_length <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_MAX_SAME_REPEAT: begin
					cfg_q.max_same_repeat <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_MAX_DIGIT_RUN: begin
					cfg_q.max_digit_run <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_MAX_VOWEL_RUN: begin
					cfg_q.max_vowel_run <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_MAX_CONSONANT_RUN: begin
					cfg_q.max_consonant_run <= cfg_wdata[iwq_pkg::LIMIT_W-1:0];
				end
				iwq_pkg::REG_VOWEL_LETTERS: begin
					cfg_q.vowel_letters <= cfg_wdata[iwq_pkg::VOWEL_W-1:0];
				end
				iwq_pkg::REG_REJECT_MODES: begin
					cfg_q.reject_modes <= cfg_wdata[iwq_pkg::MODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/iwq_char_class.sv -----
// ----------------------------------------------------------------------------
// iwq_char_class
// Sorts one byte into digit, vowel, consonant or punctuation; every other byte, letter or not, counts as a consonant.
// ----------------------------------------------------------------------------
module iwq_char_class (
	input  logic [iwq_pkg::CHAR_W-1:0]  char_code,
	input  logic [iwq_pkg::VOWEL_W-1:0] vowel_letters,
	output iwq_pkg::char_class_t        char_class
);

	logic       is_lower;
	logic       is_upper;
	logic [4:0] letter_idx;
	logic [7:0] letter_off;
	logic       is_punct;
	logic       is_digit;
	logic       is_vowel;

	always_comb begin
		is_lower   = (char_code >= 8'd97) && (char_code <= 8'd122);
		is_upper   = (char_code >= 8'd65) && (char_code <= 8'd90);
		letter_off = is_lower ? (char_code - 8'd97) : (char_code - 8'd65);
		letter_idx = letter_off[4:0];
		is_digit   = (char_code >= 8'd48) && (char_code <= 8'd57);
		is_vowel   = (is_lower || is_upper) && vowel_letters[letter_idx];
		is_punct   = ((char_code >= 8'd33) && (char_code <= 8'd47)) ||
		             ((char_code >= 8'd58) && (char_code <= 8'd64)) ||
		             ((char_code >= 8'd91) && (char_code <= 8'd96)) ||
		             ((char_code >= 8'd123) && (char_code <= 8'd126));
		char_class.is_digit     = is_digit;
		char_class.is_vowel     = is_vowel;
		char_class.is_consonant = !is_digit && !is_vowel && !is_punct;
	end

endmodule

// ----- hw/rtl/iwq_tracker.sv -----
// ----------------------------------------------------------------------------
// iwq_tracker
// Per-word counters, sticky reject and the verdict at the terminator.
// ----------------------------------------------------------------------------
module iwq_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iwq_pkg::step_t              step,
	input  logic [iwq_pkg::CHAR_W-1:0]  char_code,
	input  iwq_pkg::char_class_t        char_class,
	input  iwq_pkg::cfg_t               cfg,
	output logic                        accept
);

	logic [iwq_pkg::CNT_W-1:0]  word_length_q;
	logic [iwq_pkg::CHAR_W-1:0] previous_char_q;
	logic [iwq_pkg::CNT_W-1:0]  same_count_q;
	logic [iwq_pkg::CNT_W-1:0]  digit_run_q;
	logic [iwq_pkg::CNT_W-1:0]  vowel_run_q;
	logic [iwq_pkg::CNT_W-1:0]  consonant_run_q;
	logic                       seen_digit_q;
	logic                       seen_vowel_q;
	logic                       seen_consonant_q;
	logic                       rejected_q;

	logic [iwq_pkg::CNT_W-1:0]  same_nx;
	logic [iwq_pkg::CNT_W-1:0]  digit_nx;
	logic [iwq_pkg::CNT_W-1:0]  vowel_nx;
	logic [iwq_pkg::CNT_W-1:0]  consonant_nx;
	logic                       over_limit;

	always_comb begin
		same_nx      = '0;
		digit_nx     = digit_run_q;
		vowel_nx     = vowel_run_q;
		consonant_nx = consonant_run_q;
		if ((word_length_q != '0) && (char_code == previous_char_q)) begin
			same_nx = iwq_pkg::sat_inc(same_count_q);
		end
		priority if (char_class.is_digit) begin
			digit_nx     = iwq_pkg::sat_inc(digit_run_q);
			vowel_nx     = '0;
			consonant_nx = '0;
		end else if (char_class.is_vowel) begin
			vowel_nx     = iwq_pkg::sat_inc(vowel_run_q);
			digit_nx     = '0;
			consonant_nx = '0;
		end else if (char_class.is_consonant) begin
			consonant_nx = iwq_pkg::sat_inc(consonant_run_q);
			digit_nx     = '0;
			vowel_nx     = '0;
		end else begin
		end
		over_limit = (same_nx > {1'b0, cfg.max_same_repeat}) ||
		             (char_class.is_digit && (digit_nx > {1'b0, cfg.max_digit_run})) ||
		             (char_class.is_vowel && (vowel_nx > {1'b0, cfg.max_vowel_run})) ||
		             (char_class.is_consonant &&
		              (consonant_nx > {1'b0, cfg.max_consonant_run}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q    <= '0;
			previous_char_q  <= '0;
			same_count_q     <= '0;
			digit_run_q      <= '0;
			vowel_run_q      <= '0;
			consonant_run_q  <= '0;
			seen_digit_q     <= 1'b0;
			seen_vowel_q     <= 1'b0;
			seen_consonant_q <= 1'b0;
			rejected_q       <= 1'b0;
		end else if (step.step && step.word_end) begin
			word_length_q    <= '0;
			previous_char_q  <= '0;
			same_count_q     <= '0;
			digit_run_q      <= '0;
			vowel_run_q      <= '0;
			consonant_run_q  <= '0;
			seen_digit_q     <= 1'b0;
			seen_vowel_q     <= 1'b0;
			seen_consonant_q <= 1'b0;
			rejected_q       <= 1'b0;
		end else if (step.step) begin
			word_length_q    <= iwq_pkg::sat_inc(word_length_q);
			previous_char_q  <= char_code;
			same_count_q     <= same_nx;
			digit_run_q      <= digit_nx;
			vowel_run_q      <= vowel_nx;
			consonant_run_q  <= consonant_nx;
			seen_digit_q     <= seen_digit_q | char_class.is_digit;
			seen_vowel_q     <= seen_vowel_q | char_class.is_vowel;
			seen_consonant_q <= seen_consonant_q | char_class.is_consonant;
			rejected_q       <= rejected_q | over_limit;
		end
	end

	always_comb begin
		accept = (word_length_q != '0) && !step.is_stopword && !rejected_q &&
		         !(word_length_q < {1'b0, cfg.min_length}) &&
		         !(word_length_q > {1'b0, cfg.max_length}) &&
		         !(cfg.reject_modes[iwq_pkg::MODE_ALL_VOWEL] &&
		           seen_vowel_q && !seen_consonant_q) &&
		         !(cfg.reject_modes[iwq_pkg::MODE_ALL_CONSONANT] &&
		           seen_consonant_q && !seen_vowel_q) &&
		         !(cfg.reject_modes[iwq_pkg::MODE_ALL_DIGIT] &&
		           seen_digit_q && !seen_vowel_q && !seen_consonant_q);
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the index word qualifier. Words are streamed one
// byte per transfer, each closed by a terminator, with random gaps on both
// channels. A local model of the word counters predicts each accept flag that
// a directed row does not give; all are checked in order per register setting.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned RANDOM_ITEMS  = 900;
	localparam int unsigned PHASE_ITEMS   = 70;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned N_DIRECTED    = 22;
	localparam logic [iwq_pkg::CNT_W-1:0] CNT_TOP = 9'd256;

	typedef enum logic [2:0] {MIX, DIGITS, VOWELS, CONSONANTS, SAME, RAW} flavor_t;
	typedef enum logic [2:0] {ALL_ZERO, ALL_MAX, LOOSE_LENGTH, SHUFFLED, RESET_VALUES} setting_t;

	typedef struct packed {
		logic [iwq_pkg::CHAR_W-1:0] code;
		logic                       last;
		logic                       stop;
		logic                       typed;
		logic                       want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1'b1, 1'b0, 1'b1, 1'b0},
		'{"a",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
		'{"a",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0},
		'{"~",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{"0",   1'b0, 1'b0, 1'b0, 1'b0},
		'{"9",   1'b0, 1'b0, 1'b0, 1'b0},
		'{"A",   1'b0, 1'b0, 1'b0, 1'b0},
		'{"Z",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{"z",   1'b0, 1'b0, 1'b0, 1'b0},
		'{"z",   1'b0, 1'b0, 1'b0, 1'b0},
		'{"z",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{"!",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{"{",   1'b0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [iwq_pkg::INDEX_W-1:0]  cfg_index;
	logic [iwq_pkg::DATA_W-1:0]   cfg_wdata;
	logic                         in_valid;
	logic                         in_ready;
	logic [iwq_pkg::CHAR_W-1:0]   char_code;
	logic                         word_end;
	logic                         is_stopword;
	logic                         out_valid;
	logic                         out_ready;
	logic                         accept;

	iwq_pkg::cfg_t                cfg_shadow;
	logic [iwq_pkg::CNT_W-1:0]    len_cnt;
	logic [iwq_pkg::CNT_W-1:0]    same_cnt;
	logic [iwq_pkg::CNT_W-1:0]    digit_cnt;
	logic [iwq_pkg::CNT_W-1:0]    vowel_cnt;
	logic [iwq_pkg::CNT_W-1:0]    cons_cnt;
	logic [iwq_pkg::CHAR_W-1:0]   last_byte;
	iwq_pkg::char_class_t         seen;
	logic                         word_rejected;
	logic                         expected_accepts [$];

	int unsigned         sent = 0;
	int unsigned         fail_count = 0;
	logic                send_calm = 1'b0;
	logic                recv_calm = 1'b0;

	index_word_qualifier u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.word_end    (word_end),
		.is_stopword (is_stopword),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accept      (accept)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [iwq_pkg::CNT_W-1:0] bump(input logic [iwq_pkg::CNT_W-1:0] v);
		return (v == CNT_TOP) ? v : v + 9'd1;
	endfunction

	task automatic clear_word();
		len_cnt       = '0;
		same_cnt      = '0;
		digit_cnt     = '0;
		vowel_cnt     = '0;
		cons_cnt      = '0;
		last_byte     = '0;
		seen          = '0;
		word_rejected = 1'b0;
	endtask

	task automatic qualify(input logic [iwq_pkg::CHAR_W-1:0] code, input logic last,
			input logic stop, output logic verdict);
		logic digit;
		logic letter;
		logic vowel;
		logic punct;
		logic [iwq_pkg::CHAR_W-1:0] idx;
		verdict = 1'b0;
		if (!last) begin
			if (len_cnt != '0 && code == last_byte) begin
				same_cnt = bump(same_cnt);
				if (same_cnt > {1'b0, cfg_shadow.max_same_repeat})
					word_rejected = 1'b1;
			end else begin
				same_cnt = '0;
			end
			digit  = code >= "0" && code <= "9";
			letter = (code >= "a" && code <= "z") || (code >= "A" && code <= "Z");
			idx    = (code >= "a") ? code - "a" : code - "A";
			vowel  = 1'b0;
			if (letter)
				vowel = cfg_shadow.vowel_letters[idx];
			punct  = (code >= 8'd33 && code <= 8'd47) || (code >= 8'd58 && code <= 8'd64) ||
				(code >= 8'd91 && code <= 8'd96) || (code >= 8'd123 && code <= 8'd126);
			if (digit) begin
				seen.is_digit = 1'b1;
				digit_cnt = bump(digit_cnt);
				if (digit_cnt > {1'b0, cfg_shadow.max_digit_run})
					word_rejected = 1'b1;
				vowel_cnt = '0;
				cons_cnt  = '0;
			end else if (vowel) begin
				seen.is_vowel = 1'b1;
				vowel_cnt = bump(vowel_cnt);
				if (vowel_cnt > {1'b0, cfg_shadow.max_vowel_run})
					word_rejected = 1'b1;
				digit_cnt = '0;
				cons_cnt  = '0;
			end else if (!punct) begin
				seen.is_consonant = 1'b1;
				cons_cnt = bump(cons_cnt);
				if (cons_cnt > {1'b0, cfg_shadow.max_consonant_run})
					word_rejected = 1'b1;
				digit_cnt = '0;
				vowel_cnt = '0;
			end
			last_byte = code;
			len_cnt   = bump(len_cnt);
		end else begin
			verdict = len_cnt != '0 && !stop && !word_rejected &&
				len_cnt >= {1'b0, cfg_shadow.min_length} &&
				len_cnt <= {1'b0, cfg_shadow.max_length};
			if (cfg_shadow.reject_modes[iwq_pkg::MODE_ALL_VOWEL] && seen.is_vowel &&
					!seen.is_consonant)
				verdict = 1'b0;
			if (cfg_shadow.reject_modes[iwq_pkg::MODE_ALL_CONSONANT] && seen.is_consonant &&
					!seen.is_vowel)
				verdict = 1'b0;
			if (cfg_shadow.reject_modes[iwq_pkg::MODE_ALL_DIGIT] && seen.is_digit &&
					!seen.is_vowel && !seen.is_consonant)
				verdict = 1'b0;
			clear_word();
		end
	endtask

	function automatic logic [iwq_pkg::CHAR_W-1:0] pick_byte(input flavor_t flavor,
			input logic [iwq_pkg::CHAR_W-1:0] prev);
		logic [iwq_pkg::CHAR_W-1:0] base;
		int unsigned n;
		base = ($urandom_range(0, 1) != 0) ? "a" : "A";
		n = $urandom_range(0, 25);
		case (flavor)
			DIGITS: return "0" + 8'($urandom_range(0, 9));
			VOWELS: begin
				if (cfg_shadow.vowel_letters != '0)
					while (!cfg_shadow.vowel_letters[n])
						n = $urandom_range(0, 25);
				return base + 8'(n);
			end
			CONSONANTS: begin
				if (&cfg_shadow.vowel_letters)
					return 8'($urandom_range(128, 255));
				while (cfg_shadow.vowel_letters[n])
					n = $urandom_range(0, 25);
				return base + 8'(n);
			end
			SAME: return prev;
			RAW: return 8'($urandom_range(0, 255));
			default: begin
				case ($urandom_range(0, 5))
					0: return "0" + 8'($urandom_range(0, 9));
					1: return base + 8'(n);
					2: begin
						case ($urandom_range(0, 3))
							0: return 8'($urandom_range(33, 47));
							1: return 8'($urandom_range(58, 64));
							2: return 8'($urandom_range(91, 96));
							default: return 8'($urandom_range(123, 126));
						endcase
					end
					3: return prev;
					4: return 8'($urandom_range(0, 31));
					default: return 8'($urandom_range(0, 255));
				endcase
			end
		endcase
	endfunction

	task automatic send_item(input logic [iwq_pkg::CHAR_W-1:0] code, input logic last,
			input logic stop, input logic typed, input logic want);
		logic verdict;
		int unsigned gap;
		in_valid    <= 1'b1;
		char_code   <= code;
		word_end    <= last;
		is_stopword <= stop;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		qualify(code, last, stop, verdict);
		if (last)
			expected_accepts.push_back(typed ? want : verdict);
		sent++;
		gap = send_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_word(input flavor_t flavor, input int unsigned len);
		logic [iwq_pkg::CHAR_W-1:0] prev;
		logic [iwq_pkg::CHAR_W-1:0] code;
		prev = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		for (int unsigned i = 0; i < len; i++) begin
			code = (i == 0 && flavor == SAME) ? prev : pick_byte(flavor, prev);
			send_item(code, 1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
			prev = code;
		end
		send_item(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 7) == 0, 1'b0, 1'b0);
	endtask

	task automatic write_reg(input logic [iwq_pkg::INDEX_W-1:0] idx,
			input logic [iwq_pkg::DATA_W-1:0] value, input int unsigned width);
		logic [iwq_pkg::DATA_W-1:0] junk;
		logic [iwq_pkg::DATA_W-1:0] data;
		junk = iwq_pkg::DATA_W'($urandom);
		data = (junk << width) | value;
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			iwq_pkg::REG_MIN_LENGTH:
				cfg_shadow.min_length = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_MAX_LENGTH:
				cfg_shadow.max_length = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_MAX_SAME_REPEAT:
				cfg_shadow.max_same_repeat = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_MAX_DIGIT_RUN:
				cfg_shadow.max_digit_run = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_MAX_VOWEL_RUN:
				cfg_shadow.max_vowel_run = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_MAX_CONSONANT_RUN:
				cfg_shadow.max_consonant_run = data[iwq_pkg::LIMIT_W-1:0];
			iwq_pkg::REG_VOWEL_LETTERS:
				cfg_shadow.vowel_letters = data[iwq_pkg::VOWEL_W-1:0];
			iwq_pkg::REG_REJECT_MODES:
				cfg_shadow.reject_modes = data[iwq_pkg::MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input setting_t setting);
		iwq_pkg::cfg_t next;
		logic [iwq_pkg::INDEX_W-1:0] stray;
		case (setting)
			ALL_ZERO: next = '0;
			ALL_MAX:  next = '1;
			LOOSE_LENGTH: begin
				next.min_length        = '0;
				next.max_length        = '1;
				next.max_same_repeat   = 8'($urandom_range(0, 3));
				next.max_digit_run     = 8'($urandom_range(0, 3));
				next.max_vowel_run     = 8'($urandom_range(0, 3));
				next.max_consonant_run = 8'($urandom_range(0, 3));
				next.vowel_letters     = iwq_pkg::VOWEL_W'($urandom);
				next.reject_modes      = iwq_pkg::MODE_W'($urandom_range(0, 7));
			end
			SHUFFLED: begin
				next.min_length        = 8'($urandom_range(0, 8));
				next.max_length        = 8'($urandom_range(0, 20));
				next.max_same_repeat   = 8'($urandom_range(0, 12));
				next.max_digit_run     = 8'($urandom_range(0, 12));
				next.max_vowel_run     = 8'($urandom_range(0, 12));
				next.max_consonant_run = 8'($urandom_range(0, 12));
				next.vowel_letters     = iwq_pkg::VOWEL_W'($urandom);
				next.reject_modes      = iwq_pkg::MODE_W'($urandom_range(0, 7));
			end
			default: begin
				next = {iwq_pkg::RST_MIN_LENGTH, iwq_pkg::RST_MAX_LENGTH,
					iwq_pkg::RST_MAX_SAME_REPEAT, iwq_pkg::RST_MAX_DIGIT_RUN,
					iwq_pkg::RST_MAX_VOWEL_RUN, iwq_pkg::RST_MAX_CONSONANT_RUN,
					iwq_pkg::RST_VOWEL_LETTERS, iwq_pkg::RST_REJECT_MODES};
				next.reject_modes = iwq_pkg::MODE_W'($urandom_range(0, 7));
			end
		endcase
		write_reg(iwq_pkg::REG_MIN_LENGTH, iwq_pkg::DATA_W'(next.min_length),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_MAX_LENGTH, iwq_pkg::DATA_W'(next.max_length),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_MAX_SAME_REPEAT, iwq_pkg::DATA_W'(next.max_same_repeat),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_MAX_DIGIT_RUN, iwq_pkg::DATA_W'(next.max_digit_run),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_MAX_VOWEL_RUN, iwq_pkg::DATA_W'(next.max_vowel_run),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_MAX_CONSONANT_RUN, iwq_pkg::DATA_W'(next.max_consonant_run),
			iwq_pkg::LIMIT_W);
		write_reg(iwq_pkg::REG_VOWEL_LETTERS, iwq_pkg::DATA_W'(next.vowel_letters),
			iwq_pkg::VOWEL_W);
		write_reg(iwq_pkg::REG_REJECT_MODES, iwq_pkg::DATA_W'(next.reject_modes),
			iwq_pkg::MODE_W);
		// Writes past the last register must leave every register untouched.
		stray = ($urandom_range(0, 1) != 0) ? iwq_pkg::REG_REJECT_MODES + 8'd1 :
			8'($urandom_range(iwq_pkg::REG_REJECT_MODES + 1, 255));
		write_reg(stray, iwq_pkg::DATA_W'($urandom), 0);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_accepts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned phase;
		int unsigned phase_start;
		int unsigned r;
		int unsigned len;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= '0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		char_code   <= '0;
		word_end    <= 1'b0;
		is_stopword <= 1'b0;
		cfg_shadow = {iwq_pkg::RST_MIN_LENGTH, iwq_pkg::RST_MAX_LENGTH,
			iwq_pkg::RST_MAX_SAME_REPEAT, iwq_pkg::RST_MAX_DIGIT_RUN,
			iwq_pkg::RST_MAX_VOWEL_RUN, iwq_pkg::RST_MAX_CONSONANT_RUN,
			iwq_pkg::RST_VOWEL_LETTERS, iwq_pkg::RST_REJECT_MODES};
		clear_word();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].stop,
				DIRECTED[i].typed, DIRECTED[i].want);
		settle();
		phase = 0;
		while (sent < N_DIRECTED + RANDOM_ITEMS) begin
			configure(setting_t'(phase % 5));
			send_calm   = $urandom_range(0, 3) == 0;
			recv_calm   = $urandom_range(0, 3) == 0;
			phase_start = sent;
			// Over-long words drive the length counter into saturation; runs of one repeated byte can saturate more counters.
			if (setting_t'(phase % 5) == ALL_MAX)
				send_word(($urandom_range(0, 1) != 0) ? SAME : MIX, $urandom_range(256, 264));
			while (sent - phase_start < PHASE_ITEMS) begin
				r   = $urandom_range(0, 99);
				len = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
				send_word(flavor_t'($urandom_range(0, 5)), len);
			end
			settle();
			phase++;
		end
		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : result_sink
		int unsigned hold;
		logic want;
		hold = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_accepts.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got accept %0b",
						$time, accept);
					fail_count++;
				end else begin
					want = expected_accepts.pop_front();
					if (accept !== want) begin
						$display("%0t: accept mismatch, expected %0b, got %0b",
							$time, want, accept);
						fail_count++;
					end
				end
				hold = recv_calm ? 0 : $urandom_range(0, 9);
				if (hold != 0) begin
					out_ready <= 1'b0;
					hold--;
				end
			end else if (!out_ready) begin
				if (hold == 0)
					out_ready <= 1'b1;
				else
					hold--;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, expected_accepts.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
